/* rtl/esud_pkg.sv */
// Shared types and constants for the epoch seconds to UTC date converter.
`timescale 1ns / 1ps

package esud_pkg;

    localparam int STAGES = 9;

    // Seconds to days: (t >> 7) / 675 by reciprocal, exact over 25 bits.
    localparam logic [25:0] DAY_RECIP       = 26'd50903317;
    localparam int          DAY_RECIP_SHIFT = 35;
    localparam logic [16:0] SECS_PER_DAY    = 17'd86400;

    // Second of day to hour: (s >> 4) / 225 by reciprocal.
    localparam logic [12:0] HOUR_RECIP       = 13'd4661;
    localparam int          HOUR_RECIP_SHIFT = 20;
    localparam logic [11:0] SECS_PER_HOUR    = 12'd3600;

    // Second of hour to minute: (s >> 2) / 15 by reciprocal.
    localparam logic [10:0] MIN_RECIP       = 11'd1093;
    localparam int          MIN_RECIP_SHIFT = 14;
    localparam logic [11:0] SECS_PER_MIN    = 12'd60;

    // Days since 1970 shifted to the March era, less four full eras.
    localparam logic [17:0] ERA_OFFSET   = 18'd135080;
    localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
    localparam logic [17:0] DAYS_PER_CENT_1 = 18'd36524;
    localparam logic [17:0] DAYS_PER_CENT_2 = 18'd73048;
    localparam logic [17:0] DAYS_PER_CENT_3 = 18'd109572;
    localparam logic [17:0] DAYS_PER_CENT_4 = 18'd146096;

    // Day of era to 4-year count: (doe >> 2) / 365 by reciprocal.
    localparam logic [15:0] QUAD_RECIP       = 16'd45965;
    localparam int          QUAD_RECIP_SHIFT = 24;

    // Adjusted day of era to year of era: n / 365 by reciprocal.
    localparam logic [17:0] YEAR_RECIP       = 18'd183860;
    localparam int          YEAR_RECIP_SHIFT = 26;
    localparam logic [8:0]  DAYS_PER_YEAR    = 9'd365;

    localparam logic [11:0] YEAR_BASE_ERA4 = 12'd1600;
    localparam logic [11:0] YEAR_BASE_ERA5 = 12'd2000;

    localparam logic [3:0] MONTH_JAN = 4'd10;

    // First day of each month within a March-based year.
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    typedef struct packed {
        logic [31:0] epoch_seconds;
    } in_payload_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } out_payload_t;

    typedef struct packed {
        logic [STAGES-1:0] load;
    } pipe_ctrl_t;

endpackage

/* rtl/esud_stream_if.sv */
// Valid/ready stream channel carrying one payload.
`timescale 1ns / 1ps

interface esud_stream_if #(
    parameter type payload_t = logic [31:0]
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

/* rtl/epoch_seconds_to_utc_date.sv */
// Top level of the epoch seconds to UTC date converter.
// Converts an unsigned 32-bit Unix time into Gregorian UTC year, month (0 is January),
// day of month and time of day, matching gmtime over the whole input range. The
// datapath is a nine-stage pipeline: a request is taken every cycle unless the output
// is stalled with every stage full. Each stage of a path holds at most one constant
// multiply plus adds and compares. Stalls on the result side back up stage by stage,
// so empty stages keep filling and ready drops only when every stage holds a request.
`timescale 1ns / 1ps

module epoch_seconds_to_utc_date (
    input logic         clk,
    input logic         rst_n,
    esud_stream_if.sink   epoch,
    esud_stream_if.source calendar
);

    localparam int LAST = esud_pkg::STAGES - 1;

    logic [esud_pkg::STAGES-1:0] valid_reg;
    logic [esud_pkg::STAGES-1:0] valid_next;
    logic [esud_pkg::STAGES-1:0] adv;
    esud_pkg::pipe_ctrl_t        ctrl;
    esud_pkg::in_payload_t       req;

    logic [15:0] days;
    logic [16:0] sec_of_day;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    // Advance a stage when it is empty or its successor advances.
    always_comb
    begin
        adv[LAST] = !valid_reg[LAST] || calendar.ready;
        for (int i = LAST - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i + 1];
        end
        valid_next[0] = adv[0] ? epoch.valid : valid_reg[0];
        for (int i = 1; i < esud_pkg::STAGES; i++)
        begin
            valid_next[i] = adv[i] ? valid_reg[i - 1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load   = adv;
    assign epoch.ready = adv[0];
    assign req         = epoch.data;

    esud_day_split u_day_split (
        .clk           (clk),
        .ctrl          (ctrl),
        .epoch_seconds (req.epoch_seconds),
        .days          (days),
        .sec_of_day    (sec_of_day)
    );

    esud_tod u_tod (
        .clk        (clk),
        .ctrl       (ctrl),
        .sec_of_day (sec_of_day),
        .hour       (hour),
        .minute     (minute),
        .second     (second)
    );

    esud_civil u_civil (
        .clk          (clk),
        .ctrl         (ctrl),
        .days         (days),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month)
    );

    assign calendar.valid = valid_reg[LAST];
    assign calendar.data  = esud_pkg::out_payload_t'{
        year:         year,
        month:        month,
        day_of_month: day_of_month,
        hour:         hour,
        minute:       minute,
        second:       second
    };

endmodule

/* rtl/esud_day_split.sv */
// Split epoch seconds into whole days and second of day (stages 1 and 2).
`timescale 1ns / 1ps

module esud_day_split (
    input  logic                clk,
    input  esud_pkg::pipe_ctrl_t ctrl,
    input  logic [31:0]         epoch_seconds,
    output logic [15:0]         days,
    output logic [16:0]         sec_of_day
);

    logic [31:0] secs_reg;
    logic [50:0] prod_reg;
    logic [50:0] prod_next;
    logic [15:0] days_reg;
    logic [15:0] days_next;
    logic [31:0] day_base;
    logic [16:0] sod_reg;
    logic [16:0] sod_next;

    assign prod_next = 51'(epoch_seconds[31:7]) * 51'(esud_pkg::DAY_RECIP);

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            secs_reg <= epoch_seconds;
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        days_next = prod_reg[50:esud_pkg::DAY_RECIP_SHIFT];
        day_base  = 32'(days_next) * 32'(esud_pkg::SECS_PER_DAY);
        sod_next  = 17'(secs_reg - day_base);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            days_reg <= days_next;
            sod_reg  <= sod_next;
        end
    end

    assign days       = days_reg;
    assign sec_of_day = sod_reg;

endmodule

/* rtl/esud_tod.sv */
// Time of day: hour, minute and second from second of day (stages 3 to 9).
`timescale 1ns / 1ps

module esud_tod (
    input  logic                clk,
    input  esud_pkg::pipe_ctrl_t ctrl,
    input  logic [16:0]         sec_of_day,
    output logic [4:0]          hour,
    output logic [5:0]          minute,
    output logic [5:0]          second
);

    logic [16:0] sod3_reg;
    logic [4:0]  hour3_reg;
    logic [25:0] hour_prod;
    logic [4:0]  hour3_next;

    logic [11:0] rem4_reg;
    logic [11:0] rem4_next;
    logic [4:0]  hour4_reg;

    logic [11:0] rem5_reg;
    logic [4:0]  hour5_reg;
    logic [5:0]  min5_reg;
    logic [20:0] min_prod;
    logic [5:0]  min5_next;

    logic [16:0] tod6_next;
    logic [16:0] tod_reg [4];

    // Stage 3: estimate hour.
    always_comb
    begin
        hour_prod  = 26'(sec_of_day[16:4]) * 26'(esud_pkg::HOUR_RECIP);
        hour3_next = hour_prod[24:esud_pkg::HOUR_RECIP_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            sod3_reg  <= sec_of_day;
            hour3_reg <= hour3_next;
        end
    end

    // Stage 4: second of hour.
    assign rem4_next = 12'(sod3_reg - 17'(hour3_reg) * 17'(esud_pkg::SECS_PER_HOUR));

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            rem4_reg  <= rem4_next;
            hour4_reg <= hour3_reg;
        end
    end

    // Stage 5: minute.
    always_comb
    begin
        min_prod  = 21'(rem4_reg[11:2]) * 21'(esud_pkg::MIN_RECIP);
        min5_next = min_prod[19:esud_pkg::MIN_RECIP_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            rem5_reg  <= rem4_reg;
            hour5_reg <= hour4_reg;
            min5_reg  <= min5_next;
        end
    end

    // Stage 6: second, then hold through stage 9.
    assign tod6_next = {hour5_reg, min5_reg,
                        6'(rem5_reg - 12'(min5_reg) * esud_pkg::SECS_PER_MIN)};

    always_ff @(posedge clk)
    begin
        if (ctrl.load[5])
        begin
            tod_reg[0] <= tod6_next;
        end
        for (int i = 1; i < 4; i++)
        begin
            if (ctrl.load[5 + i])
            begin
                tod_reg[i] <= tod_reg[i - 1];
            end
        end
    end

    assign hour   = tod_reg[3][16:12];
    assign minute = tod_reg[3][11:6];
    assign second = tod_reg[3][5:0];

endmodule

/* rtl/esud_civil.sv */
// Gregorian year, month and day from days since 1970 (stages 3 to 9).
`timescale 1ns / 1ps

module esud_civil (
    input  logic                clk,
    input  esud_pkg::pipe_ctrl_t ctrl,
    input  logic [15:0]         days,
    output logic [11:0]         year,
    output logic [3:0]          month,
    output logic [4:0]          day_of_month
);

    logic [17:0] off3;
    logic        era3_next;
    logic [17:0] doe3_next;
    logic [17:0] doe3_reg;
    logic        era3_reg;

    logic [31:0] quad_prod;
    logic [6:0]  q1460_next;
    logic [2:0]  qcent_next;
    logic [17:0] doe4_reg;
    logic [6:0]  q1460_reg;
    logic [2:0]  qcent_reg;
    logic        qera_reg;
    logic        era4_reg;

    logic [17:0] n5_next;
    logic [17:0] n5_reg;
    logic [17:0] doe5_reg;
    logic        era5_reg;

    logic [35:0] year_prod;
    logic [8:0]  yoe6_next;
    logic [8:0]  yoe6_reg;
    logic [17:0] doe6_reg;
    logic        era6_reg;

    logic [1:0]  c100;
    logic [17:0] year_start;
    logic [8:0]  doy7_next;
    logic [8:0]  doy7_reg;
    logic [8:0]  yoe7_reg;
    logic        era7_reg;

    logic [3:0]  mp8_next;
    logic [3:0]  mp8_reg;
    logic [8:0]  doy8_reg;
    logic [8:0]  yoe8_reg;
    logic        era8_reg;

    logic [11:0] year_next;
    logic [3:0]  month_next;
    logic [4:0]  dom_next;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  dom_reg;

    // Stage 3: day of era.
    always_comb
    begin
        off3      = 18'(days) + esud_pkg::ERA_OFFSET;
        era3_next = (off3 >= esud_pkg::DAYS_PER_ERA);
        doe3_next = era3_next ? (off3 - esud_pkg::DAYS_PER_ERA) : off3;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            doe3_reg <= doe3_next;
            era3_reg <= era3_next;
        end
    end

    // Stage 4: leap corrections.
    always_comb
    begin
        quad_prod  = 32'(doe3_reg[17:2]) * 32'(esud_pkg::QUAD_RECIP);
        q1460_next = quad_prod[30:esud_pkg::QUAD_RECIP_SHIFT];
        qcent_next = 3'(doe3_reg >= esud_pkg::DAYS_PER_CENT_1)
                   + 3'(doe3_reg >= esud_pkg::DAYS_PER_CENT_2)
                   + 3'(doe3_reg >= esud_pkg::DAYS_PER_CENT_3)
                   + 3'(doe3_reg >= esud_pkg::DAYS_PER_CENT_4);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            doe4_reg  <= doe3_reg;
            q1460_reg <= q1460_next;
            qcent_reg <= qcent_next;
            qera_reg  <= (doe3_reg == esud_pkg::DAYS_PER_CENT_4);
            era4_reg  <= era3_reg;
        end
    end

    // Stage 5: day count on a 365-day grid.
    assign n5_next = doe4_reg - 18'(q1460_reg) + 18'(qcent_reg) - 18'(qera_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            n5_reg   <= n5_next;
            doe5_reg <= doe4_reg;
            era5_reg <= era4_reg;
        end
    end

    // Stage 6: year of era.
    always_comb
    begin
        year_prod = 36'(n5_reg) * 36'(esud_pkg::YEAR_RECIP);
        yoe6_next = year_prod[34:esud_pkg::YEAR_RECIP_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[5])
        begin
            yoe6_reg <= yoe6_next;
            doe6_reg <= doe5_reg;
            era6_reg <= era5_reg;
        end
    end

    // Stage 7: day of March-based year.
    always_comb
    begin
        c100 = 2'(yoe6_reg >= 9'd100) + 2'(yoe6_reg >= 9'd200) + 2'(yoe6_reg >= 9'd300);
        year_start = 18'(yoe6_reg) * 18'(esud_pkg::DAYS_PER_YEAR)
                   + 18'(yoe6_reg[8:2]) - 18'(c100);
        doy7_next = 9'(doe6_reg - year_start);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[6])
        begin
            doy7_reg <= doy7_next;
            yoe7_reg <= yoe6_reg;
            era7_reg <= era6_reg;
        end
    end

    // Stage 8: month of March-based year.
    always_comb
    begin
        mp8_next = '0;
        for (int i = 1; i < 12; i++)
        begin
            mp8_next = mp8_next + 4'(doy7_reg >= esud_pkg::MONTH_START[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[7])
        begin
            mp8_reg  <= mp8_next;
            doy8_reg <= doy7_reg;
            yoe8_reg <= yoe7_reg;
            era8_reg <= era7_reg;
        end
    end

    // Stage 9: calendar fields; January and February roll into the next year.
    always_comb
    begin
        dom_next   = 5'(doy8_reg - esud_pkg::MONTH_START[mp8_reg] + 9'd1);
        month_next = (mp8_reg < esud_pkg::MONTH_JAN) ? (mp8_reg + 4'd2)
                                                     : (mp8_reg - esud_pkg::MONTH_JAN);
        year_next  = 12'(yoe8_reg)
                   + (era8_reg ? esud_pkg::YEAR_BASE_ERA5 : esud_pkg::YEAR_BASE_ERA4)
                   + 12'(mp8_reg >= esud_pkg::MONTH_JAN);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[8])
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            dom_reg   <= dom_next;
        end
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = dom_reg;

endmodule
